FILE: hdl/lsw_pkg.sv
package lsw_pkg;

    // field widths
    localparam int SEQ_W     = 16;
    localparam int BRAKE_W   = 2;
    localparam int AGE_W     = 31;
    localparam int CNT_W     = 32;
    localparam int CFG_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;

    // item kinds
    localparam logic ACT_PACKET = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // link status codes
    localparam logic [STATUS_W-1:0] STATUS_WAITING = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UP      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LOST    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK   = 1'd1;

    // register reset values
    localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd500;
    localparam logic [CFG_W-1:0] BLINK_RST   = 16'd250;

    // saturation limit of the age counter
    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    typedef struct packed {
        logic [CFG_W-1:0] link_timeout;
        logic [CFG_W-1:0] blink_period_ms;
    } cfg_t;

    typedef struct packed {
        logic                       accepted;
        logic [STATUS_W-1:0]        status;
        logic                       light_on;
        logic [BRAKE_W-1:0]         held_state;
        logic [SEQ_W-1:0]           held_seq;
        logic signed [CNT_W-1:0]    age_out;
        logic [CNT_W-1:0]           accept_total;
        logic [CNT_W-1:0]           stale_total;
    } res_t;

endpackage

FILE: hdl/lsw_core.sv
module lsw_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        action,
    input  logic [lsw_pkg::SEQ_W-1:0]   seq_in,
    input  logic [lsw_pkg::BRAKE_W-1:0] brake_in,
    input  lsw_pkg::cfg_t               cfg,
    output lsw_pkg::res_t               res
);
    import lsw_pkg::*;

    logic               seen_reg, seen_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [BRAKE_W-1:0] brake_reg, brake_next;
    logic [AGE_W-1:0]   age_reg, age_next;
    logic [CNT_W-1:0]   acc_cnt_reg, acc_cnt_next;
    logic [CNT_W-1:0]   stale_cnt_reg, stale_cnt_next;
    logic [CFG_W-1:0]   blink_cnt_reg, blink_cnt_next;
    logic               toggle_reg, toggle_next;
    logic               light_reg, light_next;

    logic [SEQ_W-1:0]   seq_diff;
    logic               newer;
    logic               take;
    logic [CFG_W-1:0]   period;
    logic [CFG_W-1:0]   blink_inc;
    logic               eval;
    logic               up_next;

    // serial-number compare: newer when difference is nonzero and below half range
    assign seq_diff = seq_in - seq_reg;
    assign newer    = (seq_diff != '0) && !seq_diff[SEQ_W-1];
    assign take     = !seen_reg || newer;

    // blink period, zero acts as one
    assign period    = (cfg.blink_period_ms == '0) ? CFG_W'(1) : cfg.blink_period_ms;
    assign blink_inc = blink_cnt_reg + CFG_W'(1);
    assign eval      = (blink_inc == '0) || (blink_inc >= period);

    // next state for one word
    always_comb
    begin
        seen_next      = seen_reg;
        seq_next       = seq_reg;
        brake_next     = brake_reg;
        age_next       = age_reg;
        acc_cnt_next   = acc_cnt_reg;
        stale_cnt_next = stale_cnt_reg;
        blink_cnt_next = blink_cnt_reg;
        toggle_next    = toggle_reg;
        light_next     = light_reg;
        if (action == ACT_PACKET)
        begin
            if (take)
            begin
                seen_next    = 1'b1;
                seq_next     = seq_in;
                brake_next   = brake_in;
                age_next     = '0;
                acc_cnt_next = acc_cnt_reg + CNT_W'(1);
            end
            else
            begin
                stale_cnt_next = stale_cnt_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (seen_reg && (age_reg != AGE_MAX))
            begin
                age_next = age_reg + AGE_W'(1);
            end
            blink_cnt_next = blink_inc;
            if (eval)
            begin
                blink_cnt_next = '0;
                if (seen_reg && (age_next <= AGE_W'(cfg.link_timeout)))
                begin
                    light_next = (brake_reg != '0);
                end
                else
                begin
                    toggle_next = !toggle_reg;
                    light_next  = !toggle_reg;
                end
            end
        end
    end

    // snapshot after the update
    assign up_next = age_next <= AGE_W'(cfg.link_timeout);

    always_comb
    begin
        res.accepted     = (action == ACT_PACKET) && take;
        res.status       = !seen_next ? STATUS_WAITING : (up_next ? STATUS_UP : STATUS_LOST);
        res.light_on     = light_next;
        res.held_state   = brake_next;
        res.held_seq     = seq_next;
        res.age_out      = seen_next ? $signed({1'b0, age_next}) : -32'sd1;
        res.accept_total = acc_cnt_next;
        res.stale_total  = stale_cnt_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            seq_reg       <= '0;
            brake_reg     <= '0;
            age_reg       <= '0;
            acc_cnt_reg   <= '0;
            stale_cnt_reg <= '0;
            blink_cnt_reg <= '0;
            toggle_reg    <= 1'b0;
            light_reg     <= 1'b0;
        end
        else if (step)
        begin
            seen_reg      <= seen_next;
            seq_reg       <= seq_next;
            brake_reg     <= brake_next;
            age_reg       <= age_next;
            acc_cnt_reg   <= acc_cnt_next;
            stale_cnt_reg <= stale_cnt_next;
            blink_cnt_reg <= blink_cnt_next;
            toggle_reg    <= toggle_next;
            light_reg     <= light_next;
        end
    end

endmodule

FILE: hdl/link_sequence_watchdog_top.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready   | action, seq_in, brake_in
// out     | output    | out_valid/out_ready | accepted, status, light_on, held_state,
//         |           |                     | held_seq, age_out, accept_total, stale_total
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// one word per cycle while the result side is not stalled; each word's result appears in the cycle after it is taken
// the rate is set by the single state update between the input and the result register
// reset clears link state, counters and the result valid; registers return to 500 and 250
// a stalled result holds; a new word is still taken in the cycle the result leaves
module link_sequence_watchdog_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [lsw_pkg::SEQ_W-1:0]     seq_in,
    input  logic [lsw_pkg::BRAKE_W-1:0]   brake_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          accepted,
    output logic [lsw_pkg::STATUS_W-1:0]  status,
    output logic                          light_on,
    output logic [lsw_pkg::BRAKE_W-1:0]   held_state,
    output logic [lsw_pkg::SEQ_W-1:0]     held_seq,
    output logic signed [lsw_pkg::CNT_W-1:0] age_out,
    output logic [lsw_pkg::CNT_W-1:0]     accept_total,
    output logic [lsw_pkg::CNT_W-1:0]     stale_total,
    input  logic                          cfg_we,
    input  logic [lsw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lsw_pkg::CFG_W-1:0]     cfg_data
);
    import lsw_pkg::*;

    cfg_t cfg_reg;
    res_t res_next;
    res_t res_reg;
    logic valid_reg;
    logic step;

    // output register frees itself when taken
    assign in_ready = !valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_timeout    <= TIMEOUT_RST;
            cfg_reg.blink_period_ms <= BLINK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMEOUT: cfg_reg.link_timeout    <= cfg_data;
                REG_BLINK:   cfg_reg.blink_period_ms <= cfg_data;
                default:     cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    lsw_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .action   (action),
        .seq_in   (seq_in),
        .brake_in (brake_in),
        .cfg      (cfg_reg),
        .res      (res_next)
    );

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = valid_reg;
    assign accepted     = res_reg.accepted;
    assign status       = res_reg.status;
    assign light_on     = res_reg.light_on;
    assign held_state   = res_reg.held_state;
    assign held_seq     = res_reg.held_seq;
    assign age_out      = res_reg.age_out;
    assign accept_total = res_reg.accept_total;
    assign stale_total  = res_reg.stale_total;

endmodule

FILE: hdl/lsw_checker.sv
module lsw_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          accepted,
    input  logic [lsw_pkg::STATUS_W-1:0]  status,
    input  logic signed [lsw_pkg::CNT_W-1:0] age_out,
    input  logic [lsw_pkg::CNT_W-1:0]     accept_total
);
    import lsw_pkg::*;

    // a stalled result word stays presented
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid;
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result word dropped while stalled");

    // every taken word yields a result next cycle
    property p_in_to_out;
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid;
    endproperty
    a_in_to_out: assert property (p_in_to_out) else $error("taken word produced no result");

    // a freshly accepted packet leaves the link up
    property p_acc_up;
        @(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> status == STATUS_UP && age_out == 32'sd0;
    endproperty
    a_acc_up: assert property (p_acc_up) else $error("accepted packet without up status");

    // waiting means no packet was ever taken
    property p_waiting;
        @(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_WAITING |-> age_out == -32'sd1 && accept_total == '0;
    endproperty
    a_waiting: assert property (p_waiting) else $error("waiting status with packet history");

endmodule

bind link_sequence_watchdog_top lsw_checker u_lsw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted     (accepted),
    .status       (status),
    .age_out      (age_out),
    .accept_total (accept_total)
);

FILE: verif/link_watchdog_checker.sv
module link_watchdog_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             action,
    input  logic [lsw_pkg::SEQ_W-1:0]        seq_in,
    input  logic [lsw_pkg::BRAKE_W-1:0]      brake_in,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             accepted,
    input  logic [lsw_pkg::STATUS_W-1:0]     status,
    input  logic                             light_on,
    input  logic [lsw_pkg::BRAKE_W-1:0]      held_state,
    input  logic [lsw_pkg::SEQ_W-1:0]        held_seq,
    input  logic signed [lsw_pkg::CNT_W-1:0] age_out,
    input  logic [lsw_pkg::CNT_W-1:0]        accept_total,
    input  logic [lsw_pkg::CNT_W-1:0]        stale_total,
    input  logic                             cfg_we,
    input  logic [lsw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsw_pkg::CFG_W-1:0]        cfg_data,
    output int                               error_count,
    output int                               pending_words,
    output int                               checked_words
);
    timeunit 1ns;
    timeprecision 1ps;
    import lsw_pkg::*;

    localparam int PRINT_CAP = 40;

    // register copies
    logic [CFG_W-1:0] timeout_reg;
    logic [CFG_W-1:0] blink_reg;

    // link state copy
    logic               got_packet;
    logic [SEQ_W-1:0]   link_seq;
    logic [BRAKE_W-1:0] link_brake;
    logic [AGE_W-1:0]   link_age;
    logic [CNT_W-1:0]   accept_cnt;
    logic [CNT_W-1:0]   stale_cnt;
    logic [CFG_W-1:0]   blink_cnt;
    logic               flash_phase;
    logic               lamp;

    // snapshots still owed by the block, oldest first
    res_t snapshot_q[$];

    task automatic report_mismatch(input string detail);
        if (error_count < PRINT_CAP)
            $display("%0t: mismatch: %s", $time, detail);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got)
            report_mismatch($sformatf("%s expected %h got %h", name, want, got));
    endtask

    function automatic logic [STATUS_W-1:0] link_state();
        if (!got_packet)
            return STATUS_WAITING;
        return (link_age > AGE_W'(timeout_reg)) ? STATUS_LOST : STATUS_UP;
    endfunction

    // advance the link state by one word and return its snapshot
    function automatic res_t step_link(input logic act, input logic [SEQ_W-1:0] s,
                                       input logic [BRAKE_W-1:0] b);
        res_t             r;
        logic [SEQ_W-1:0] diff;
        logic [CFG_W-1:0] period;
        r = '0;
        if (act == ACT_PACKET) begin
            // newer only for a nonzero distance below half the sequence space
            diff = s - link_seq;
            if (!got_packet || (diff != '0 && !diff[SEQ_W-1])) begin
                link_seq   = s;
                link_brake = b;
                link_age   = '0;
                got_packet = 1'b1;
                accept_cnt = accept_cnt + 1'b1;
                r.accepted = 1'b1;
            end
            else begin
                stale_cnt = stale_cnt + 1'b1;
            end
        end
        else begin
            // tick: age, count, then evaluate the light at the period
            period = (blink_reg == '0) ? CFG_W'(1) : blink_reg;
            if (got_packet && link_age != AGE_MAX)
                link_age = link_age + 1'b1;
            blink_cnt = blink_cnt + 1'b1;
            if (blink_cnt == '0 || blink_cnt >= period) begin
                blink_cnt = '0;
                if (link_state() == STATUS_UP) begin
                    lamp = (link_brake != '0);
                end
                else begin
                    flash_phase = !flash_phase;
                    lamp        = flash_phase;
                end
            end
        end
        r.status       = link_state();
        r.light_on     = lamp;
        r.held_state   = link_brake;
        r.held_seq     = link_seq;
        r.age_out      = got_packet ? $signed({1'b0, link_age}) : {CNT_W{1'b1}};
        r.accept_total = accept_cnt;
        r.stale_total  = stale_cnt;
        return r;
    endfunction

    // watch the channels, predict and compare
    always @(posedge clk or negedge rst_n) begin
        res_t want;
        if (!rst_n) begin
            timeout_reg   = TIMEOUT_RST;
            blink_reg     = BLINK_RST;
            got_packet    = 1'b0;
            link_seq      = '0;
            link_brake    = '0;
            link_age      = '0;
            accept_cnt    = '0;
            stale_cnt     = '0;
            blink_cnt     = '0;
            flash_phase   = 1'b0;
            lamp          = 1'b0;
            snapshot_q.delete();
            pending_words <= 0;
        end
        else begin
            // result word leaving the block
            if (out_valid && out_ready) begin
                if (snapshot_q.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end
                else begin
                    want = snapshot_q.pop_front();
                    check_field("accepted", CNT_W'(want.accepted), CNT_W'(accepted));
                    check_field("status", CNT_W'(want.status), CNT_W'(status));
                    check_field("light_on", CNT_W'(want.light_on), CNT_W'(light_on));
                    check_field("held_state", CNT_W'(want.held_state), CNT_W'(held_state));
                    check_field("held_seq", CNT_W'(want.held_seq), CNT_W'(held_seq));
                    check_field("age_out", want.age_out, age_out);
                    check_field("accept_total", want.accept_total, accept_total);
                    check_field("stale_total", want.stale_total, stale_total);
                end
                checked_words++;
            end
            // register writes
            if (cfg_we) begin
                if (cfg_index == REG_TIMEOUT)
                    timeout_reg = cfg_data;
                else if (cfg_index == REG_BLINK)
                    blink_reg = cfg_data;
            end
            // input word taken
            if (in_valid && in_ready)
                snapshot_q.push_back(step_link(action, seq_in, brake_in));
            pending_words <= snapshot_q.size();
        end
    end

endmodule

FILE: verif/tb_link_sequence_watchdog_top.sv
module tb_link_sequence_watchdog_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lsw_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic                    action;
    logic [SEQ_W-1:0]        seq_in;
    logic [BRAKE_W-1:0]      brake_in;
    logic                    out_valid;
    logic                    out_ready;
    logic                    accepted;
    logic [STATUS_W-1:0]     status;
    logic                    light_on;
    logic [BRAKE_W-1:0]      held_state;
    logic [SEQ_W-1:0]        held_seq;
    logic signed [CNT_W-1:0] age_out;
    logic [CNT_W-1:0]        accept_total;
    logic [CNT_W-1:0]        stale_total;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;

    int error_count;
    int pending_words;
    int checked_words;
    int words_sent = 0;
    int settings_used = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    logic [SEQ_W-1:0] next_seq = '0;

    link_sequence_watchdog_top dut (.*);

    link_watchdog_checker chk (.*);

    always #6 clk = ~clk;

    // end the run if nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_link_sequence_watchdog_top: done, errors");
                $finish;
            end
        end
    end

    // result side stalls: mostly short, a few long, some long open stretches
    initial begin
        int on_len;
        int off_len;
        int r;
        out_ready <= 1'b0;
        @(posedge clk);
        forever begin
            on_len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 4)
                                                  : $urandom_range(10, 60);
            r = $urandom_range(0, 99);
            if (r < 45)
                off_len = 0;
            else if (r < 85)
                off_len = $urandom_range(1, 3);
            else if (r < 97)
                off_len = $urandom_range(4, 10);
            else
                off_len = $urandom_range(20, 40);
            out_ready <= 1'b1;
            repeat (on_len) @(posedge clk);
            if (off_len > 0) begin
                out_ready <= 1'b0;
                repeat (off_len) @(posedge clk);
            end
        end
    end

    // sender gap before the next word
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            burst_left = $urandom_range(10, 50);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 35);
    endfunction

    task automatic send_word(input logic act, input logic [SEQ_W-1:0] s,
                             input logic [BRAKE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        seq_in   <= s;
        brake_in <= b;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    task automatic send_tick();
        send_word(ACT_TICK, SEQ_W'($urandom), BRAKE_W'($urandom));
    endtask

    // wait until every snapshot is back and the block is quiet
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_words != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] timeout_val,
                              input logic [CFG_W-1:0] blink_ms);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TIMEOUT;
        cfg_data  <= timeout_val;
        @(posedge clk);
        cfg_index <= REG_BLINK;
        cfg_data  <= blink_ms;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // mostly in-order packets and ticks, with stale and random packets mixed in
    task automatic run_random(input int count);
        int done_items;
        int r;
        int k;
        logic [SEQ_W-1:0] s;
        done_items = 0;
        while (done_items < count) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                // silent stretch, long enough to lose the link at small timeouts
                k = $urandom_range(5, 40);
                repeat (k) send_tick();
                done_items += k;
            end
            else if (r < 45) begin
                send_tick();
                done_items++;
            end
            else if (r < 80) begin
                if ($urandom_range(0, 9) == 0)
                    next_seq = next_seq + SEQ_W'($urandom_range(1, 16'h7FFF));
                else
                    next_seq = next_seq + SEQ_W'($urandom_range(1, 4));
                send_word(ACT_PACKET, next_seq, BRAKE_W'($urandom));
                done_items++;
            end
            else if (r < 92) begin
                // repeated, older or half-way sequence
                case ($urandom_range(0, 2))
                    0: s = next_seq;
                    1: s = next_seq - SEQ_W'($urandom_range(1, 16'h7FFF));
                    default: s = next_seq + 16'h8000;
                endcase
                send_word(ACT_PACKET, s, BRAKE_W'($urandom));
                done_items++;
            end
            else begin
                send_word(ACT_PACKET, SEQ_W'($urandom), BRAKE_W'($urandom));
                done_items++;
            end
        end
    endtask

    initial begin
        in_valid  <= 1'b0;
        action    <= ACT_PACKET;
        seq_in    <= '0;
        brake_in  <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_TIMEOUT;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ticks before any packet, reset register values
        send_tick();
        send_tick();
        drain();

        // sequence edge cases with a short timeout and blink period
        set_config(16'd3, 16'd2);
        send_word(ACT_PACKET, 16'hFFFF, 2'd3);
        send_word(ACT_PACKET, 16'h0000, 2'd0);
        send_word(ACT_PACKET, 16'h0000, 2'd1);
        send_word(ACT_PACKET, 16'h8000, 2'd2);
        send_word(ACT_PACKET, 16'h7FFF, 2'd2);
        send_word(ACT_PACKET, 16'h7FFE, 2'd1);
        send_word(ACT_TICK, 16'hFFFF, 2'd3);
        send_word(ACT_TICK, 16'h0000, 2'd0);
        repeat (4) send_tick();
        send_word(ACT_PACKET, 16'h8000, 2'd0);
        repeat (2) send_tick();
        drain();

        // zero timeout and zero blink period
        set_config(16'd0, 16'd0);
        repeat (3) send_tick();
        send_word(ACT_PACKET, 16'h8001, 2'd3);
        send_tick();
        drain();

        // largest settings, then a period lowered below the running count
        set_config(16'hFFFF, 16'hFFFF);
        next_seq = 16'h8001;
        run_random(200);
        drain();
        set_config(16'd2, 16'd3);
        run_random(250);
        for (int p = 0; p < 3; p++) begin
            drain();
            set_config(CFG_W'($urandom_range(0, 60)), CFG_W'($urandom_range(0, 15)));
            run_random(250);
        end
        drain();
        set_config(16'd0, 16'd1);
        run_random(200);
        drain();
        set_config(16'd20, 16'd0);
        run_random(150);
        drain();
        set_config(CFG_W'($urandom), CFG_W'($urandom));
        run_random(150);
        drain();

        $display("covered %0d words over %0d register settings, %0d snapshots checked",
                 words_sent, settings_used, checked_words);
        if (error_count == 0)
            $display("tb_link_sequence_watchdog_top: done, clean");
        else
            $display("tb_link_sequence_watchdog_top: done, errors");
        $finish;
    end

endmodule
